/* hw/rtl/vcl_pkg.sv */
package vcl_pkg;

  // Field widths of the request and result words
  localparam int unsigned COORD_W = 5;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned LEN_W   = 6;

  // Request actions
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  // One axis of the line walk: position and error term
  typedef struct packed {
    logic [COORD_W-1:0] pos;
    logic [COORD_W-1:0] err;
  } axis_t;

  // One Bresenham step on a single axis
  function automatic axis_t axis_step(axis_t a, logic [COORD_W-1:0] d,
                                      logic [COORD_W-1:0] dm, logic up);
    axis_t            r;
    logic [COORD_W:0] e;
    e     = {1'b0, a.err} - {1'b0, d};
    r.pos = a.pos;
    if (e[COORD_W]) begin
      e     = e + {1'b0, dm};
      r.pos = up ? a.pos + 1'b1 : a.pos - 1'b1;
    end
    r.err = e[COORD_W-1:0];
    return r;
  endfunction

endpackage

/* hw/rtl/vcl_if.sv */
// Request channel: voxel write or chord measure
interface vcl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [vcl_pkg::COORD_W-1:0] start_x;
  logic [vcl_pkg::COORD_W-1:0] start_y;
  logic [vcl_pkg::COORD_W-1:0] start_z;
  logic [vcl_pkg::COORD_W-1:0] end_x;
  logic [vcl_pkg::COORD_W-1:0] end_y;
  logic [vcl_pkg::COORD_W-1:0] end_z;
  logic [vcl_pkg::VAL_W-1:0]   voxel_value;

  modport source (output valid, action, start_x, start_y, start_z,
                  end_x, end_y, end_z, voxel_value, input ready);
  modport sink   (input valid, action, start_x, start_y, start_z,
                  end_x, end_y, end_z, voxel_value, output ready);
endinterface

// Result channel: chord length
interface vcl_out_if;
  logic                      valid;
  logic                      ready;
  logic [vcl_pkg::LEN_W-1:0] chord_len;

  modport source (output valid, chord_len, input ready);
  modport sink   (input valid, chord_len, output ready);
endinterface

/* hw/rtl/vcl_voxel_ram.sv */
// Voxel store: one write port, one read port with registered read data
module vcl_voxel_ram #(
  parameter int unsigned AW = 15,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/voxel_chord_length_top.sv */
// Voxel write: stored when accepted; the next word can be accepted on the following cycle.
// Chord measure: SETUP finds dm, the largest axis difference, then WALK reads one voxel
// per step along the line until a voxel differs from target_value or the line ends.
// Out-of-range chord: result 0, straight to DONE. One word is worked on at a time, and a
// finished result that cannot yet enter the full output register holds off the next word.
// Reset clears the sequencer, output valid and target_value; voxels stay undefined.
module voxel_chord_length_top #(
  parameter int unsigned SIDE = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  vcl_in_if.sink   in_i,
  vcl_out_if.source out_o
);
  import vcl_pkg::*;

  localparam int unsigned CW = $clog2(SIDE);
  localparam int unsigned AW = 3 * CW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               target_q;
  axis_t              ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic [COORD_W-1:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic               ux_q, ux_d, uy_q, uy_d, uz_q, uz_d;
  logic [COORD_W-1:0] dm_q, dm_d, left_q, left_d;
  logic               more_q, more_d, pend_q, pend_d, last_q, last_d;
  logic [LEN_W-1:0]   count_q, count_d, res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic [LEN_W-1:0]   out_len_q;

  logic               in_acc, out_load, rng_ok, wr_en, hit;
  logic [COORD_W-1:0] dm_xy;
  logic [AW-1:0]      waddr, raddr;
  logic [VAL_W-1:0]   rdata;
  logic [CW+COORD_W-1:0] wxe, wye, wze, rxe, rye, rze;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Range check on all six coordinates
  assign rng_ok = (32'(in_i.start_x) < SIDE) && (32'(in_i.start_y) < SIDE) &&
                  (32'(in_i.start_z) < SIDE) && (32'(in_i.end_x) < SIDE) &&
                  (32'(in_i.end_y) < SIDE) && (32'(in_i.end_z) < SIDE);

  // Memory addressing: coordinates packed as {z, y, x}
  assign wxe   = {{CW{1'b0}}, in_i.start_x};
  assign wye   = {{CW{1'b0}}, in_i.start_y};
  assign wze   = {{CW{1'b0}}, in_i.start_z};
  assign rxe   = {{CW{1'b0}}, ax_q.pos};
  assign rye   = {{CW{1'b0}}, ay_q.pos};
  assign rze   = {{CW{1'b0}}, az_q.pos};
  assign waddr = {wze[CW-1:0], wye[CW-1:0], wxe[CW-1:0]};
  assign raddr = {rze[CW-1:0], rye[CW-1:0], rxe[CW-1:0]};
  assign wr_en = in_acc && (in_i.action == ACT_WRITE) &&
                 (32'(in_i.start_x) < SIDE) && (32'(in_i.start_y) < SIDE) &&
                 (32'(in_i.start_z) < SIDE);

  vcl_voxel_ram #(
    .AW(AW),
    .DW(VAL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(waddr),
    .wdata_i(in_i.voxel_value),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign hit   = (rdata == {{(VAL_W-1){1'b0}}, target_q});
  assign dm_xy = (dy_q > dx_q) ? dy_q : dx_q;

  // Sequencer and step unit
  always_comb begin
    state_d = state_q;
    ax_d = ax_q; ay_d = ay_q; az_d = az_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q;
    ux_d = ux_q; uy_d = uy_q; uz_d = uz_q;
    dm_d = dm_q; left_d = left_q;
    more_d = more_q; pend_d = pend_q; last_d = last_q;
    count_d = count_q; res_d = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.action == ACT_MEASURE)) begin
          ax_d.pos = in_i.start_x;
          ay_d.pos = in_i.start_y;
          az_d.pos = in_i.start_z;
          ux_d = in_i.start_x < in_i.end_x;
          uy_d = in_i.start_y < in_i.end_y;
          uz_d = in_i.start_z < in_i.end_z;
          dx_d = ux_d ? in_i.end_x - in_i.start_x : in_i.start_x - in_i.end_x;
          dy_d = uy_d ? in_i.end_y - in_i.start_y : in_i.start_y - in_i.end_y;
          dz_d = uz_d ? in_i.end_z - in_i.start_z : in_i.start_z - in_i.end_z;
          if (rng_ok) begin
            state_d = S_SETUP;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_SETUP: begin
        dm_d     = (dz_q > dm_xy) ? dz_q : dm_xy;
        ax_d.err = dm_d >> 1;
        ay_d.err = dm_d >> 1;
        az_d.err = dm_d >> 1;
        left_d   = dm_d;
        more_d   = 1'b1;
        pend_d   = 1'b0;
        last_d   = 1'b0;
        count_d  = '0;
        state_d  = S_WALK;
      end
      S_WALK: begin
        // issue a read of the current voxel and advance the line
        pend_d = more_q;
        if (more_q) begin
          last_d = (left_q == '0);
          if (left_q == '0) begin
            more_d = 1'b0;
          end else begin
            left_d = left_q - 1'b1;
            ax_d   = axis_step(ax_q, dx_q, dm_q, ux_q);
            ay_d   = axis_step(ay_q, dy_q, dm_q, uy_q);
            az_d   = axis_step(az_q, dz_q, dm_q, uz_q);
          end
        end
        // check the voxel read in the previous cycle
        if (pend_q) begin
          if (!hit) begin
            res_d   = count_q;
            state_d = S_DONE;
          end else begin
            count_d = count_q + 1'b1;
            if (last_q) begin
              res_d   = count_d;
              state_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      target_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d; ay_q <= ay_d; az_q <= az_d;
    dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d;
    ux_q <= ux_d; uy_q <= uy_d; uz_q <= uz_d;
    dm_q <= dm_d; left_q <= left_d;
    res_q <= res_d;
    if (out_load) begin
      out_len_q <= res_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.chord_len = out_len_q;

  // Checks on the walk sequencer
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (count_q <= {1'b0, dm_q} + 6'd1))
    else $error("chord count beyond line length");

  a_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && (state_q == S_WALK) |-> $past(state_q) == S_WALK)
    else $error("pending read without a walk step");

  a_left_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) && ($past(state_q) == S_WALK) |-> left_q <= $past(left_q))
    else $error("step counter went up");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result word without a finished item");

endmodule

/* dv/voxel_chord_length_top_tb.sv */
module voxel_chord_length_top_tb;
  import vcl_pkg::*;

  localparam int unsigned SIDE      = 32;
  localparam int unsigned VOXELS    = SIDE * SIDE * SIDE;
  localparam int unsigned SETTLE    = 40;    // longest chord plus margin
  localparam int unsigned HOLD_LEN  = 400;   // long receiver hold-off
  localparam int unsigned QUIET_MAX = 4000;  // cycles without any accepted word
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] sx, sy, sz;
    logic [COORD_W-1:0] ex, ey, ez;
    logic [VAL_W-1:0]   val;
  } vox_req_t;

  typedef int unsigned addr_q_t[$];

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  vcl_in_if  req_if ();
  vcl_out_if chord_if ();

  voxel_chord_length_top #(.SIDE(SIDE)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (chord_if)
  );

  // Stimulus and prediction state
  vox_req_t         word_q[$];
  logic [LEN_W-1:0] chord_q[$];
  logic [VAL_W-1:0] vox_mem[VOXELS];
  bit               planned[VOXELS];
  logic             target_bit;
  bit               hold_go;
  bit               no_idle;
  int unsigned      words_queued;
  int unsigned      words_sent;
  int unsigned      writes_sent;
  int unsigned      chords_checked;
  int unsigned      longest_chord;
  int unsigned      cfg_writes;
  int unsigned      err_count;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned vox_addr(int x, int y, int z);
    return (z * SIDE + y) * SIDE + x;
  endfunction

  // Voxels visited by the full 3D line walk, start voxel first
  function automatic addr_q_t trace_line(vox_req_t r);
    addr_q_t path;
    int x, y, z, tx, ty, tz;
    int dx, dy, dz, stx, sty, stz, dm;
    int errx, erry, errz;
    x  = int'(r.sx);
    y  = int'(r.sy);
    z  = int'(r.sz);
    tx = int'(r.ex);
    ty = int'(r.ey);
    tz = int'(r.ez);
    dx = (tx > x) ? tx - x : x - tx;
    dy = (ty > y) ? ty - y : y - ty;
    dz = (tz > z) ? tz - z : z - tz;
    stx = (x < tx) ? 1 : -1;
    sty = (y < ty) ? 1 : -1;
    stz = (z < tz) ? 1 : -1;
    dm = dx;
    if (dy > dm) dm = dy;
    if (dz > dm) dm = dz;
    errx = dm / 2;
    erry = dm / 2;
    errz = dm / 2;
    for (int k = 0; k <= dm; k++) begin
      path.push_back(vox_addr(x, y, z));
      errx -= dx;
      if (errx < 0) begin
        errx += dm;
        x += stx;
      end
      erry -= dy;
      if (erry < 0) begin
        erry += dm;
        y += sty;
      end
      errz -= dz;
      if (errz < 0) begin
        errz += dm;
        z += stz;
      end
    end
    return path;
  endfunction

  // Apply one accepted word to the voxel copy, queue the chord length it yields
  function automatic void predict_word(vox_req_t r);
    addr_q_t          path;
    logic [LEN_W-1:0] run_len;
    bit               stopped;
    if (r.action == ACT_WRITE) begin
      vox_mem[vox_addr(int'(r.sx), int'(r.sy), int'(r.sz))] = r.val;
      writes_sent++;
    end else begin
      path    = trace_line(r);
      run_len = '0;
      stopped = 1'b0;
      foreach (path[k]) begin
        if (!stopped) begin
          if (vox_mem[path[k]] != {{(VAL_W-1){1'b0}}, target_bit}) stopped = 1'b1;
          else run_len++;
        end
      end
      chord_q.push_back(run_len);
    end
  endfunction

  task automatic queue_write(int x, int y, int z, logic [VAL_W-1:0] v);
    vox_req_t r;
    r.action = ACT_WRITE;
    r.sx     = COORD_W'(x);
    r.sy     = COORD_W'(y);
    r.sz     = COORD_W'(z);
    r.ex     = COORD_W'($urandom_range(0, SIDE - 1));
    r.ey     = COORD_W'($urandom_range(0, SIDE - 1));
    r.ez     = COORD_W'($urandom_range(0, SIDE - 1));
    r.val    = v;
    planned[vox_addr(x, y, z)] = 1'b1;
    word_q.push_back(r);
    words_queued++;
  endtask

  task automatic queue_chord(int sx, int sy, int sz, int ex, int ey, int ez);
    vox_req_t r;
    r.action = ACT_MEASURE;
    r.sx     = COORD_W'(sx);
    r.sy     = COORD_W'(sy);
    r.sz     = COORD_W'(sz);
    r.ex     = COORD_W'(ex);
    r.ey     = COORD_W'(ey);
    r.ez     = COORD_W'(ez);
    r.val    = VAL_W'($urandom_range(0, 255));
    word_q.push_back(r);
    words_queued++;
  endtask

  // Chord whose path is written first (mode 0: only voxels not yet planned); mode sets how often a voxel breaks the run
  task automatic plan_chord(int sx, int sy, int sz, int ex, int ey, int ez, int mode);
    vox_req_t         r;
    addr_q_t          path;
    logic [VAL_W-1:0] v;
    int               miss_div;
    r.sx = COORD_W'(sx);
    r.sy = COORD_W'(sy);
    r.sz = COORD_W'(sz);
    r.ex = COORD_W'(ex);
    r.ey = COORD_W'(ey);
    r.ez = COORD_W'(ez);
    path = trace_line(r);
    case (mode)
      2:       miss_div = 3;
      3:       miss_div = 0;
      default: miss_div = 24;
    endcase
    foreach (path[k]) begin
      if (!planned[path[k]] || mode != 0) begin
        v = {{(VAL_W-1){1'b0}}, target_bit};
        if (miss_div != 0 && $urandom_range(0, miss_div - 1) == 0)
          v = $urandom_range(0, 1) ? {{(VAL_W-1){1'b0}}, ~target_bit}
                                   : VAL_W'($urandom_range(0, 255));
        queue_write(int'(path[k] % SIDE), int'((path[k] / SIDE) % SIDE),
                    int'(path[k] / (SIDE * SIDE)), v);
      end
    end
    queue_chord(sx, sy, sz, ex, ey, ez);
  endtask

  // Some random voxel writes; mostly short chords in a small region, some across the whole cube
  task automatic run_random_phase(int unsigned quota);
    int unsigned first;
    int          bx, by, bz, sel, axis, mode, span;
    int          c[6];
    first = words_queued;
    bx    = $urandom_range(0, SIDE - 8);
    by    = $urandom_range(0, SIDE - 8);
    bz    = $urandom_range(0, SIDE - 8);
    while (words_queued - first < quota) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        queue_write($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                    $urandom_range(0, SIDE - 1),
                    $urandom_range(0, 1) ? VAL_W'($urandom_range(0, 255))
                                         : VAL_W'($urandom_range(0, 1)));
      end else begin
        span = (sel >= 80) ? SIDE - 1 : 7;
        for (int k = 0; k < 6; k++)
          c[k] = (span == 7) ? ((k % 3 == 0) ? bx : (k % 3 == 1) ? by : bz) +
                               $urandom_range(0, 7)
                             : $urandom_range(0, SIDE - 1);
        // Longest chords: one axis runs from face to face
        if (sel >= 96) begin
          axis     = $urandom_range(0, 2);
          c[axis]  = $urandom_range(0, 1) ? SIDE - 1 : 0;
          c[axis + 3] = SIDE - 1 - c[axis];
        end
        sel  = $urandom_range(0, 9);
        mode = (sel < 4) ? 0 : (sel < 7) ? 1 : (sel < 9) ? 2 : 3;
        plan_chord(c[0], c[1], c[2], c[3], c[4], c[5], mode);
      end
    end
  endtask

  // Wait until the block has nothing left in flight
  task automatic wait_idle();
    while (words_sent != words_queued || chord_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_target(logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    target_bit   = v;
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Request driver
  vox_req_t    cur_word;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_word(cur_word);
        words_sent++;
        if (!no_idle && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 14);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          cur_word = word_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.action      <= cur_word.action;
          req_if.start_x     <= cur_word.sx;
          req_if.start_y     <= cur_word.sy;
          req_if.start_z     <= cur_word.sz;
          req_if.end_x       <= cur_word.ex;
          req_if.end_y       <= cur_word.ey;
          req_if.end_z       <= cur_word.ez;
          req_if.voxel_value <= cur_word.val;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stall bursts, one long hold-off on request
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_started;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_if.ready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      hold_started = 1'b0;
    end else begin
      if (hold_go && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        chord_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        chord_if.ready <= 1'b0;
      end else begin
        chord_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // Result monitor
  logic [LEN_W-1:0] want_len;

  always @(posedge clk_i) begin
    if (rst_ni && chord_if.valid && chord_if.ready) begin
      if (chord_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("ERROR: chord length %0d with no chord pending", chord_if.chord_len);
      end else begin
        want_len = chord_q.pop_front();
        chords_checked++;
        if (want_len > longest_chord) longest_chord = 32'(want_len);
        if (chord_if.chord_len !== want_len) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("ERROR: chord length expected %0d, got %0d", want_len,
                     chord_if.chord_len);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (chord_if.valid && chord_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("ERROR: no word accepted for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = 1'b0;
    req_if.valid         = 1'b0;
    req_if.action        = ACT_WRITE;
    req_if.start_x       = '0;
    req_if.start_y       = '0;
    req_if.start_z       = '0;
    req_if.end_x         = '0;
    req_if.end_y         = '0;
    req_if.end_z         = '0;
    req_if.voxel_value   = '0;
    chord_if.ready       = 1'b0;
    target_bit           = 1'b0;
    hold_go              = 1'b0;
    no_idle              = 1'b0;
    words_queued         = 0;
    words_sent           = 0;
    writes_sent          = 0;
    chords_checked       = 0;
    longest_chord        = 0;
    cfg_writes           = 0;
    err_count            = 0;
    quiet_cycles         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: corner voxels, extreme values, single-voxel and reversed chords
    set_target(1'b0);
    queue_write(0, 0, 0, 8'h00);
    queue_write(1, 0, 0, 8'h00);
    queue_write(SIDE - 1, SIDE - 1, SIDE - 1, 8'hFF);
    queue_write(SIDE - 1, 0, SIDE - 1, 8'h01);
    queue_write(0, SIDE - 1, 0, 8'hAA);
    queue_chord(0, 0, 0, 0, 0, 0);
    queue_chord(0, 0, 0, 1, 0, 0);
    queue_chord(1, 0, 0, 0, 0, 0);
    queue_chord(SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1);
    queue_chord(SIDE - 1, 0, SIDE - 1, SIDE - 1, 0, SIDE - 1);
    queue_chord(0, SIDE - 1, 0, 0, SIDE - 1, 0);
    queue_write(0, 0, 0, 8'h01);
    queue_chord(0, 0, 0, 1, 0, 0);
    queue_chord(1, 0, 0, 0, 0, 0);
    queue_write(SIDE - 1, SIDE - 1, SIDE - 1, 8'h00);
    queue_chord(SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1);
    wait_idle();

    // Random phases, alternating target value
    set_target(1'b1);
    run_random_phase(480);
    hold_go = 1'b1;
    wait_idle();

    set_target(1'b0);
    run_random_phase(480);
    wait_idle();

    set_target(1'b1);
    run_random_phase(480);
    wait_idle();

    // Last part runs without idling on either side
    no_idle = 1'b1;
    set_target(1'b0);
    run_random_phase(480);
    wait_idle();

    $display("Run covered %0d words: %0d voxel writes and %0d chords, longest run %0d",
             words_sent, writes_sent, chords_checked, longest_chord);
    $display("target_value written %0d times across both settings, %0d mismatches",
             cfg_writes, err_count);
    if (err_count == 0 && chord_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
